// ----- hdl/nrg_pkg.sv -----
// nrg_pkg: widths, register indexes and shared constants for the nuclear
// repulsion gradient block. Used by the channel interfaces and the top level.
// No dependencies.
package nrg_pkg;

	// Field widths
	localparam int COORD_W  = 32;
	localparam int CHARGE_W = 7;
	localparam int GRAD_W   = 48;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;

	// Datapath widths
	localparam int AXES     = 3;
	localparam int MAG_W    = COORD_W + 1;          // |d| up to 2^32 - 1
	localparam int ZZ_W     = 2 * CHARGE_W;         // Za*Zb
	localparam int SQ_W     = 2 * MAG_W;            // one square, with room for the sum
	localparam int RAD_W    = SQ_W + 2;             // radicand padded to whole digit pairs
	localparam int ROOT_W   = RAD_W / 2;            // floor(sqrt(r2))
	localparam int SREM_W   = ROOT_W + 3;           // root remainder after digit shift
	localparam int DEN_W    = SQ_W + ROOT_W;        // r2 * r
	localparam int PROD_W   = ZZ_W + MAG_W;         // Za*Zb*|d|
	localparam int QUO_W    = GRAD_W;               // quotient bits kept
	localparam int FRAC_PAD = 56 - QUO_W;           // num = prod * 2^56, top part enters first
	localparam int DREM_W   = DEN_W + 1;            // division remainder after shift

	// Step counts of the serial units
	localparam int SQ_STEPS   = MAG_W;
	localparam int SUM_STEPS  = 2;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = QUO_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	// Saturation limits of the Q24.24 sums
	localparam logic [GRAD_W-1:0] GRAD_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
	localparam logic [GRAD_W-1:0] GRAD_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_TARGET_X      = 2'd0,
		REG_TARGET_Y      = 2'd1,
		REG_TARGET_Z      = 2'd2,
		REG_TARGET_CHARGE = 2'd3
	} reg_idx_t;

	localparam logic [CHARGE_W-1:0] TARGET_CHARGE_RST = CHARGE_W'(1);

endpackage

// ----- hdl/nrg_atom_if.sv -----
// nrg_atom_if: input channel carrying one atom (position, charge, last mark).
// Depends on nrg_pkg.
interface nrg_atom_if;
	import nrg_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [COORD_W-1:0]  other_x;
	logic signed [COORD_W-1:0]  other_y;
	logic signed [COORD_W-1:0]  other_z;
	logic        [CHARGE_W-1:0] other_charge;
	logic                       last_atom;

	modport source (
		output valid, other_x, other_y, other_z, other_charge, last_atom,
		input  ready
	);

	modport sink (
		input  valid, other_x, other_y, other_z, other_charge, last_atom,
		output ready
	);

endinterface

// ----- hdl/nrg_grad_if.sv -----
// nrg_grad_if: result channel carrying the three gradient sums and the
// saturation flag. Depends on nrg_pkg.
interface nrg_grad_if;
	import nrg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [GRAD_W-1:0] grad_x;
	logic signed [GRAD_W-1:0] grad_y;
	logic signed [GRAD_W-1:0] grad_z;
	logic                     saturated;

	modport source (
		output valid, grad_x, grad_y, grad_z, saturated,
		input  ready
	);

	modport sink (
		input  valid, grad_x, grad_y, grad_z, saturated,
		output ready
	);

endinterface

// ----- hdl/nuclear_repulsion_gradient.sv -----
// Each accepted atom runs through the square, sum, root, divide and accumulate states
// in turn; a coincident pair leaves after the first root step and adds nothing.
// A last atom then loads the result register in the emit state. Atoms are taken
// only in the idle state, after the prior one clears the bit-serial squarer,
// one-digit root and one-bit-per-cycle dividers. Reset (arst_n, async) clears
// the sums and saturation flag and loads the target registers with 0,0,0,1.
// nuclear_repulsion_gradient: top level. Depends on nrg_pkg, nrg_atom_if, nrg_grad_if.
module nuclear_repulsion_gradient (
	input  logic                        clk,
	input  logic                        arst_n,
	nrg_atom_if.sink                    atom,
	nrg_grad_if.source                  grad,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nrg_pkg::ADDR_W-1:0]  paddr,
	input  logic [nrg_pkg::DATA_W-1:0]  pwdata,
	output logic [nrg_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import nrg_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SQUARE = 7'b0000010,
		S_SUM    = 7'b0000100,
		S_ROOT   = 7'b0001000,
		S_DIV    = 7'b0010000,
		S_ACC    = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q;

	// Configuration
	logic signed [COORD_W-1:0] tgt_x_q, tgt_y_q, tgt_z_q;
	logic [CHARGE_W-1:0]       tgt_charge_q;
	reg_idx_t                  reg_idx;
	logic                      cfg_wr;

	// Per-item shared datapath
	logic [ZZ_W-1:0]           zz_q;
	logic                      last_q;
	logic [SQ_W-1:0]           part_q;
	logic [SQ_W-1:0]           r2_q;
	logic [RAD_W-1:0]          rad_q;
	logic [SREM_W-1:0]         srem_q;
	logic [ROOT_W-1:0]         root_q;
	logic [DEN_W-1:0]          den_q;

	// Lanes, one per axis
	logic signed [COORD_W-1:0] tgt_c [AXES];
	logic signed [COORD_W-1:0] oth_c [AXES];
	logic [SQ_W-1:0]           sq_q  [AXES];
	logic signed [GRAD_W-1:0]  sum_q [AXES];
	logic [AXES-1:0]           lane_sat;

	// Result register
	logic                      out_valid_q;
	logic signed [GRAD_W-1:0]  out_x_q, out_y_q, out_z_q;
	logic                      out_sat_q;
	logic                      sat_q;

	logic                      in_acc;
	logic                      emit_go;
	logic                      r2_zero;

	// Root digit step
	logic [SREM_W-1:0]         srem_sh;
	logic [SREM_W-1:0]         trial;
	logic                      root_bit;

	assign in_acc  = atom.valid & atom.ready;
	assign emit_go = (state_q == S_EMIT) && (!out_valid_q || grad.ready);
	assign r2_zero = (r2_q == '0);

	assign atom.ready     = (state_q == S_IDLE);
	assign grad.valid     = out_valid_q;
	assign grad.grad_x    = out_x_q;
	assign grad.grad_y    = out_y_q;
	assign grad.grad_z    = out_z_q;
	assign grad.saturated = out_sat_q;

	// APB register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		case (reg_idx)
			REG_TARGET_X:      prdata = tgt_x_q;
			REG_TARGET_Y:      prdata = tgt_y_q;
			REG_TARGET_Z:      prdata = tgt_z_q;
			REG_TARGET_CHARGE: prdata = DATA_W'(tgt_charge_q);
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_x_q      <= '0;
			tgt_y_q      <= '0;
			tgt_z_q      <= '0;
			tgt_charge_q <= TARGET_CHARGE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TARGET_X:      tgt_x_q      <= pwdata[COORD_W-1:0];
				REG_TARGET_Y:      tgt_y_q      <= pwdata[COORD_W-1:0];
				REG_TARGET_Z:      tgt_z_q      <= pwdata[COORD_W-1:0];
				REG_TARGET_CHARGE: tgt_charge_q <= pwdata[CHARGE_W-1:0];
				default:           ;
			endcase
		end
	end

	assign tgt_c[0] = tgt_x_q;
	assign tgt_c[1] = tgt_y_q;
	assign tgt_c[2] = tgt_z_q;
	assign oth_c[0] = atom.other_x;
	assign oth_c[1] = atom.other_y;
	assign oth_c[2] = atom.other_z;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_acc)
						state_q <= S_SQUARE;
				end
				S_SQUARE: begin
					if (cnt_q == CNT_W'(SQ_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SUM;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SUM: begin
					if (cnt_q == CNT_W'(SUM_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_ROOT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ROOT: begin
					// Coincident atoms: nothing to add
					if (cnt_q == '0 && r2_zero) begin
						cnt_q   <= '0;
						state_q <= last_q ? S_EMIT : S_IDLE;
					end else if (cnt_q == CNT_W'(ROOT_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_ACC;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ACC: begin
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (emit_go)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			zz_q   <= ZZ_W'(tgt_charge_q) * ZZ_W'(atom.other_charge);
			last_q <= atom.last_atom;
		end
	end

	// Square sum, root digit recurrence and r2*r built from root bits MSB first
	assign srem_sh  = {srem_q[SREM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial    = SREM_W'({root_q, 2'b01});
	assign root_bit = (srem_sh >= trial);

	always_ff @(posedge clk) begin
		if (state_q == S_SUM) begin
			if (cnt_q == '0) begin
				part_q <= sq_q[0] + sq_q[1];
			end else begin
				r2_q   <= part_q + sq_q[2];
				rad_q  <= RAD_W'(part_q + sq_q[2]);
				srem_q <= '0;
				root_q <= '0;
				den_q  <= '0;
			end
		end else if (state_q == S_ROOT) begin
			srem_q <= root_bit ? (srem_sh - trial) : srem_sh;
			root_q <= {root_q[ROOT_W-2:0], root_bit};
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			den_q  <= {den_q[DEN_W-2:0], 1'b0} + (root_bit ? DEN_W'(r2_q) : DEN_W'(0));
		end
	end

	// Per-axis lanes: difference, serial square, serial divide, saturating sum
	for (genvar g = 0; g < AXES; g++) begin : g_lane
		logic [MAG_W-1:0]        d_c;
		logic [MAG_W-1:0]        mag_c;
		logic [MAG_W-1:0]        mag_q;
		logic [MAG_W-1:0]        mb_q;
		logic                    neg_q;
		logic [PROD_W-1:0]       prod_c;
		logic [DREM_W-1:0]       drem_q;
		logic [DREM_W-1:0]       drem_sh;
		logic                    q_bit;
		logic [QUO_W-1:0]        quo_q;
		logic                    ovf_q;
		logic                    term_sat;
		logic [GRAD_W-1:0]       term;
		logic signed [GRAD_W:0]  nv;
		logic                    acc_ovf;

		// d = target - other, 33 bits
		assign d_c   = {tgt_c[g][COORD_W-1], tgt_c[g]} - {oth_c[g][COORD_W-1], oth_c[g]};
		assign mag_c = d_c[MAG_W-1] ? (~d_c + 1'b1) : d_c;

		assign prod_c  = PROD_W'(zz_q) * PROD_W'(mag_q);
		assign drem_sh = {drem_q[DREM_W-2:0], 1'b0};
		assign q_bit   = (drem_sh >= DREM_W'(den_q));

		// Term magnitude, clamped when the quotient needs more than 47 bits
		assign term_sat = ovf_q | quo_q[QUO_W-1];
		assign term     = term_sat ? GRAD_MAX : {1'b0, quo_q[QUO_W-2:0]};
		assign nv       = neg_q ? ({sum_q[g][GRAD_W-1], sum_q[g]} + {1'b0, term})
		                        : ({sum_q[g][GRAD_W-1], sum_q[g]} - {1'b0, term});
		assign acc_ovf  = nv[GRAD_W] ^ nv[GRAD_W-1];

		assign lane_sat[g] = term_sat | acc_ovf;

		always_ff @(posedge clk) begin
			if (in_acc) begin
				neg_q    <= d_c[MAG_W-1];
				mag_q    <= mag_c;
				mb_q     <= mag_c;
				sq_q[g]  <= '0;
			end else if (state_q == S_SQUARE) begin
				// MSB-first shift and add
				sq_q[g] <= {sq_q[g][SQ_W-2:0], 1'b0} + (mb_q[MAG_W-1] ? SQ_W'(mag_q) : SQ_W'(0));
				mb_q    <= {mb_q[MAG_W-2:0], 1'b0};
			end

			if (state_q == S_SUM && cnt_q == '0) begin
				// Upper numerator bits; the rest of prod*2^56 is zero
				drem_q <= DREM_W'({prod_c, FRAC_PAD'(0)});
			end else if (state_q == S_DIV) begin
				if (cnt_q == '0)
					ovf_q <= (drem_q >= DREM_W'(den_q));
				drem_q <= q_bit ? (drem_sh - DREM_W'(den_q)) : drem_sh;
				quo_q  <= {quo_q[QUO_W-2:0], q_bit};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_q[g] <= '0;
			end else if (emit_go) begin
				sum_q[g] <= '0;
			end else if (state_q == S_ACC) begin
				if (acc_ovf)
					sum_q[g] <= nv[GRAD_W] ? GRAD_MIN : GRAD_MAX;
				else
					sum_q[g] <= nv[GRAD_W-1:0];
			end
		end
	end

	// Saturation flag and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_go)
				sat_q <= 1'b0;
			else if (state_q == S_ACC && (|lane_sat))
				sat_q <= 1'b1;

			if (emit_go)
				out_valid_q <= 1'b1;
			else if (grad.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_x_q   <= sum_q[0];
			out_y_q   <= sum_q[1];
			out_z_q   <= sum_q[2];
			out_sat_q <= sat_q;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DIV_STEPS - 1))
		else $error("step counter past the longest unit");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0 && !sat_q))
		else $error("sums not cleared after result load");

	a_wait_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !emit_go) |=> ($stable(sum_q[0]) && $stable(sat_q)))
		else $error("sums changed while result waits");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(grad.valid) |-> $past(state_q == S_EMIT))
		else $error("result valid without a last atom");
`endif

endmodule
